// ===== rtl/core/ncw_pkg.sv =====
// shared types and constants of the newreno congestion window block
package ncw_pkg;

	// field widths
	localparam int BYTES_W = 16;
	localparam int TIME_W  = 63;
	localparam int CNT_W   = 62;
	localparam int WIN_W   = 32;
	localparam int DIV_W   = 32;
	localparam int CMD_W   = 2;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;
	localparam int FACT_W  = 16;

	// packed stream widths
	localparam int IN_DATA_W  = 392;
	localparam int OUT_DATA_W = 136;

	// register reset values
	localparam logic [BYTES_W-1:0] MDS_RESET  = 16'd1200;
	localparam logic [WIN_W-1:0]   IWND_RESET = 32'd12000;
	localparam logic [WIN_W-1:0]   MWND_RESET = 32'd2400;
	localparam logic [FACT_W-1:0]  FACT_RESET = 16'd32768;

	// event kinds
	typedef enum logic [CMD_W-1:0] {
		CMD_SENT = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_ECN  = 2'd2,
		CMD_LOST = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MAX_DGRAM = 2'd0,
		REG_INIT_WND  = 2'd1,
		REG_MIN_WND   = 2'd2,
		REG_LOSS_FACT = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/core/ncw_divider.sv =====
// serial restoring divider, one quotient bit per cycle
module ncw_divider
	import ncw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_diff;
	logic           fits;

	// trial subtraction of the shifted remainder
	always_comb begin
		rem_sh   = {rem_q, quo_q[DIV_W-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		fits     = rem_sh >= {1'b0, dvs_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/newreno_congestion_window.sv =====
// NewReno congestion window: one event per item, one status result per event.
// Sends, acks that do not divide and events that leave the window alone pass
// through the execute and finish states; a congestion event also takes a
// registered multiply step between them. An ack in congestion avoidance waits
// for the serial 32-bit divider, which computes datagram size times acked bytes
// over cwnd one bit per cycle. The block takes the next event once the previous
// one has finished; a result waiting in the output register does not block
// acceptance, but it holds the following event in its final step. Congestion
// events scale the window with a 32x16 product in a registered multiply step.
module newreno_congestion_window
	import ncw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// event requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// packet_bytes, tx_time, ce_count, pkt_number, largest_lost_time,
	// persist_period, now_time
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [CMD_W-1:0]      s_tuser,
	// batch_last
	input  logic                  s_tlast,
	// status results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// credit_ok, window_open, inflight_bytes, cwnd_bytes, slow_start_threshold,
	// zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// configuration registers
	logic [BYTES_W-1:0] mds_q;
	logic [WIN_W-1:0]   min_wnd_q;
	logic [FACT_W-1:0]  fact_q;

	// congestion state
	logic [WIN_W-1:0]  inflight_q;
	logic [WIN_W-1:0]  cwnd_q;
	logic [WIN_W-1:0]  ssthresh_q;
	logic [TIME_W-1:0] recovery_q;
	logic [CNT_W-1:0]  ce_seen_q;
	logic [CNT_W:0]    expected_q;
	logic              run_valid_q;
	logic              run_broken_q;
	logic              collapse_q;
	logic [WIN_W+FACT_W-1:0] prod_q;

	// latched request
	cmd_t               cmd_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TIME_W-1:0]  sent_q;
	logic [CNT_W-1:0]   ce_q;
	logic [CNT_W-1:0]   pn_q;
	logic [TIME_W-1:0]  largest_q;
	logic [TIME_W-1:0]  period_q;
	logic [TIME_W-1:0]  now_q;
	logic               last_q;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_q;

	state_t state_q, state_d;

	logic s_acc;
	logic out_free;
	logic div_start;
	logic div_done;
	logic [DIV_W-1:0] div_quo;

	// event decode
	logic [WIN_W:0]    inflight_add;
	logic [WIN_W-1:0]  inflight_sat;
	logic [WIN_W-1:0]  inflight_sub;
	logic [WIN_W:0]    cwnd_add;
	logic [WIN_W-1:0]  cwnd_add_sat;
	logic [WIN_W:0]    cwnd_quo;
	logic [WIN_W-1:0]  cwnd_quo_sat;
	logic              sent_after;
	logic              ack_grow;
	logic              need_div;
	logic              ce_rise;
	logic              in_period;
	logic              run_valid_n;
	logic              run_broken_n;
	logic              collapse_n;
	logic              lost_event;
	logic              need_mul;
	logic [DIV_W-1:0]  div_dividend;
	logic [WIN_W-1:0]  scaled;
	logic [WIN_W-1:0]  floored;

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		inflight_add = {1'b0, inflight_q} + {{(WIN_W+1-BYTES_W){1'b0}}, bytes_q};
		inflight_sat = inflight_add[WIN_W] ? '1 : inflight_add[WIN_W-1:0];
		inflight_sub = (inflight_q > {{(WIN_W-BYTES_W){1'b0}}, bytes_q})
			? inflight_q - {{(WIN_W-BYTES_W){1'b0}}, bytes_q} : '0;
		cwnd_add     = {1'b0, cwnd_q} + {{(WIN_W+1-BYTES_W){1'b0}}, bytes_q};
		cwnd_add_sat = cwnd_add[WIN_W] ? '1 : cwnd_add[WIN_W-1:0];
		cwnd_quo     = {1'b0, cwnd_q} + {1'b0, div_quo};
		cwnd_quo_sat = cwnd_quo[WIN_W] ? '1 : cwnd_quo[WIN_W-1:0];
		sent_after   = sent_q > recovery_q;
		ack_grow     = (cmd_q == CMD_ACK) && sent_after;
		need_div     = ack_grow && (cwnd_q >= ssthresh_q) && (cwnd_q != '0);
		ce_rise      = ce_q > ce_seen_q;
		in_period    = ({1'b0, sent_q} + {1'b0, period_q}) >= {1'b0, largest_q};
		run_broken_n = run_broken_q
			|| (in_period && run_valid_q && (expected_q != {1'b0, pn_q}));
		run_valid_n  = run_valid_q || in_period;
		collapse_n   = run_valid_n && !run_broken_n;
		lost_event   = (cmd_q == CMD_LOST) && last_q && (largest_q > recovery_q);
		need_mul     = ((cmd_q == CMD_ECN) && ce_rise && sent_after) || lost_event;
		div_dividend = {{(DIV_W-BYTES_W){1'b0}}, mds_q}
			* {{(DIV_W-BYTES_W){1'b0}}, bytes_q};
		scaled       = prod_q[WIN_W+FACT_W-1:FACT_W];
		floored      = (scaled < min_wnd_q) ? min_wnd_q : scaled;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_acc) state_d = ST_EXEC;
			ST_EXEC: begin
				if (need_div)      state_d = ST_DIV;
				else if (need_mul) state_d = ST_MUL;
				else               state_d = ST_FIN;
			end
			ST_DIV:  if (div_done) state_d = ST_FIN;
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_EXEC: div_start = need_div;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mds_q     <= MDS_RESET;
			min_wnd_q <= MWND_RESET;
			fact_q    <= FACT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_DGRAM: mds_q     <= cfg_data[BYTES_W-1:0];
				// initial window only sets the window at reset
				REG_INIT_WND:  ;
				REG_MIN_WND:   min_wnd_q <= cfg_data[WIN_W-1:0];
				REG_LOSS_FACT: fact_q    <= cfg_data[FACT_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q     <= cmd_t'(s_tuser);
			bytes_q   <= s_tdata[15:0];
			sent_q    <= s_tdata[78:16];
			ce_q      <= s_tdata[140:79];
			pn_q      <= s_tdata[202:141];
			largest_q <= s_tdata[265:203];
			period_q  <= s_tdata[328:266];
			now_q     <= s_tdata[391:329];
			last_q    <= s_tlast;
		end
	end

	// window product for a congestion event
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) prod_q <= cwnd_q * fact_q;
	end

	// congestion state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			cwnd_q       <= IWND_RESET;
			ssthresh_q   <= '1;
			recovery_q   <= '0;
			ce_seen_q    <= '0;
			expected_q   <= '0;
			run_valid_q  <= 1'b0;
			run_broken_q <= 1'b0;
			collapse_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					collapse_q <= lost_event && collapse_n;
					case (cmd_q)
						CMD_SENT: inflight_q <= inflight_sat;
						CMD_ACK: begin
							inflight_q <= inflight_sub;
							if (ack_grow && !need_div) cwnd_q <= cwnd_add_sat;
						end
						CMD_ECN: begin
							if (ce_rise) begin
								ce_seen_q <= ce_q;
								if (sent_after) recovery_q <= now_q;
							end
						end
						CMD_LOST: begin
							inflight_q <= inflight_sub;
							if (in_period) expected_q <= {1'b0, pn_q} + 1'b1;
							if (last_q) begin
								run_valid_q  <= 1'b0;
								run_broken_q <= 1'b0;
								if (lost_event) begin
									recovery_q <= now_q;
								end else if (collapse_n) begin
									cwnd_q <= min_wnd_q;
								end
							end else begin
								run_valid_q  <= run_valid_n;
								run_broken_q <= run_broken_n;
							end
						end
						default: ;
					endcase
				end
				ST_DIV: if (div_done) cwnd_q <= cwnd_quo_sat;
				ST_MUL: begin
					ssthresh_q <= floored;
					cwnd_q     <= collapse_q ? min_wnd_q : floored;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_q[0]       <= inflight_q < cwnd_q;
			out_q[32:1]    <= (inflight_q < cwnd_q) ? cwnd_q - inflight_q : '0;
			out_q[64:33]   <= inflight_q;
			out_q[96:65]   <= cwnd_q;
			out_q[128:97]  <= ssthresh_q;
			out_q[135:129] <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	ncw_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cwnd_q),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the newreno congestion window block
`timescale 1ns / 100ps

module tb;
	import ncw_pkg::*;

	// one event request as the testbench sees it
	typedef struct {
		cmd_t              kind;
		logic [15:0]       bytes;
		logic [62:0]       sent;
		logic [61:0]       ce;
		logic [61:0]       pn;
		logic [62:0]       largest;
		logic [62:0]       period;
		logic [62:0]       now;
		logic              last;
	} cc_item_t;

	// one status result
	typedef struct {
		logic              credit;
		logic [31:0]       room;
		logic [31:0]       inflight;
		logic [31:0]       cwnd;
		logic [31:0]       ssthresh;
	} cc_status_t;

	localparam int QUIET_LIMIT = 4000;
	localparam int RX_HOLD     = 300;
	localparam logic [62:0] TIME_MAX = {63{1'b1}};
	localparam logic [61:0] CNT_MAX  = {62{1'b1}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	reg_idx_t              cfg_index = REG_MAX_DGRAM;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// packet_bytes, tx_time, ce_count, pkt_number, largest_lost_time,
	// persist_period, now_time
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// cmd
	cmd_t                  s_tuser = CMD_SENT;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// credit_ok, window_open, inflight_bytes, cwnd_bytes, slow_start_threshold,
	// zero fill
	logic [OUT_DATA_W-1:0] m_tdata;

	newreno_congestion_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted register settings
	logic [15:0] mds_cfg  = MDS_RESET;
	logic [31:0] mwnd_cfg = MWND_RESET;
	logic [15:0] fact_cfg = FACT_RESET;

	// predicted window state
	logic [31:0] inflight_q = '0;
	logic [31:0] cwnd_q     = IWND_RESET;
	logic [31:0] ssthresh_q = '1;
	logic [63:0] recovery_q = '0;
	logic [61:0] ce_q       = '0;
	logic [63:0] next_pn_q  = '0;
	logic        run_open_q   = 1'b0;
	logic        run_broken_q = 1'b0;

	cc_status_t status_due[$];

	// run bookkeeping
	int          mismatches = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          settings_done = 0;
	int          quiet_cycles = 0;
	logic [63:0] t_now = 64'd1000;
	logic [61:0] ce_ctr = '0;
	logic [63:0] pn_ctr = 64'd100;
	bit          tx_steady = 1'b0;
	logic        rx_steady = 1'b0;
	logic [7:0]  hold_req = '0;
	logic [7:0]  hold_ack = '0;
	int          hold_left = 0;

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {33'd0, a} + {1'b0, b};
		return (s > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] minus_floor(logic [31:0] a, logic [15:0] b);
		return (a > {16'd0, b}) ? a - {16'd0, b} : 32'd0;
	endfunction

	// window cut on ecn or loss, skipped while the time lies inside recovery
	function automatic void cut_window(logic [63:0] t, logic [62:0] now_t);
		logic [47:0] scaled;
		if (t > recovery_q) begin
			recovery_q = {1'b0, now_t};
			scaled = {16'd0, cwnd_q} * {32'd0, fact_cfg};
			cwnd_q = scaled[47:16];
			if (cwnd_q < mwnd_cfg)
				cwnd_q = mwnd_cfg;
			ssthresh_q = cwnd_q;
		end
	endfunction

	// advance the predicted state by one event and return the status it yields
	function automatic cc_status_t next_window_status(cc_item_t it);
		logic [63:0] inc;
		logic [63:0] reach;
		cc_status_t st;
		case (it.kind)
			CMD_SENT: begin
				inflight_q = sat_add32(inflight_q, {48'd0, it.bytes});
			end
			CMD_ACK: begin
				inflight_q = minus_floor(inflight_q, it.bytes);
				if ({1'b0, it.sent} > recovery_q) begin
					if (cwnd_q < ssthresh_q || cwnd_q == 32'd0) begin
						cwnd_q = sat_add32(cwnd_q, {48'd0, it.bytes});
					end else begin
						inc = ({48'd0, mds_cfg} * {48'd0, it.bytes}) / {32'd0, cwnd_q};
						cwnd_q = sat_add32(cwnd_q, inc);
					end
				end
			end
			CMD_ECN: begin
				if (it.ce > ce_q) begin
					ce_q = it.ce;
					cut_window({1'b0, it.sent}, it.now);
				end
			end
			default: begin
				inflight_q = minus_floor(inflight_q, it.bytes);
				reach = {1'b0, it.sent} + {1'b0, it.period};
				if (reach >= {1'b0, it.largest}) begin
					if (run_open_q && next_pn_q != {2'b0, it.pn})
						run_broken_q = 1'b1;
					run_open_q = 1'b1;
					next_pn_q = {2'b0, it.pn} + 64'd1;
				end
				if (it.last) begin
					cut_window({1'b0, it.largest}, it.now);
					if (run_open_q && !run_broken_q)
						cwnd_q = mwnd_cfg;
					run_open_q = 1'b0;
					run_broken_q = 1'b0;
				end
			end
		endcase
		st.credit = inflight_q < cwnd_q;
		st.room = st.credit ? cwnd_q - inflight_q : 32'd0;
		st.inflight = inflight_q;
		st.cwnd = cwnd_q;
		st.ssthresh = ssthresh_q;
		return st;
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	function automatic logic [61:0] rand62();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[61:0];
	endfunction

	function automatic cc_item_t cc_item(cmd_t kind, logic [15:0] bytes, logic [62:0] sent,
			logic [61:0] ce, logic [61:0] pn, logic [62:0] largest,
			logic [62:0] period, logic last);
		cc_item_t it;
		it.kind = kind;
		it.bytes = bytes;
		it.sent = sent;
		it.ce = ce;
		it.pn = pn;
		it.largest = largest;
		it.period = period;
		it.now = t_now[62:0];
		it.last = last;
		return it;
	endfunction

	// offer one request, wait for the handshake, record the expected status
	task automatic send_item(cc_item_t it);
		if (!tx_steady) begin
			while ($urandom_range(99) < 28) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.now, it.period, it.largest, it.pn, it.ce, it.sent, it.bytes};
		s_tuser <= it.kind;
		s_tlast <= it.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		status_due.push_back(next_window_status(it));
		items_sent++;
		t_now = t_now + 64'($urandom_range(1, 1500));
	endtask

	// wait until every status has come back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write all four registers back to back while idle
	task automatic apply_settings(logic [15:0] mds, logic [31:0] iwnd, logic [31:0] mwnd,
			logic [15:0] fact);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_DGRAM;
		cfg_data <= {16'd0, mds};
		@(posedge clk);
		cfg_index <= REG_INIT_WND;
		cfg_data <= iwnd;
		@(posedge clk);
		cfg_index <= REG_MIN_WND;
		cfg_data <= mwnd;
		@(posedge clk);
		cfg_index <= REG_LOSS_FACT;
		cfg_data <= {16'd0, fact};
		@(posedge clk);
		cfg_we <= 1'b0;
		mds_cfg = mds;
		mwnd_cfg = mwnd;
		fact_cfg = fact;
		settings_done++;
		@(posedge clk);
	endtask

	// sends at the extremes and acks in and out of recovery
	task automatic test_reset_defaults();
		send_item(cc_item(CMD_SENT, 16'hFFFF, '0, '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_SENT, 16'd0, '0, '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'd1000, t_now[62:0], '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'd2000, '0, '0, '0, '0, '0, 1'b0));
	endtask

	// ce count rises, repeats, falls, rises inside recovery; then avoidance acks
	task automatic test_ecn_reaction();
		send_item(cc_item(CMD_ECN, 16'd0, t_now[62:0], 62'd3, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ECN, 16'd0, t_now[62:0], 62'd3, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ECN, 16'd0, t_now[62:0], 62'd2, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ECN, 16'd0, '0, 62'd5, '0, '0, '0, 1'b0));
		ce_ctr = 62'd5;
		send_item(cc_item(CMD_ACK, 16'd1200, t_now[62:0], '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'hFFFF, t_now[62:0], '0, '0, '0, '0, 1'b0));
	endtask

	// unbroken run collapses, a gap breaks the run, an early packet stays outside
	task automatic test_loss_batches();
		logic [62:0] base;
		base = t_now[62:0];
		send_item(cc_item(CMD_LOST, 16'd500, base, '0, 62'd10, base + 63'd20, 63'd100, 1'b0));
		send_item(cc_item(CMD_LOST, 16'd500, base + 63'd10, '0, 62'd11, base + 63'd20,
			63'd100, 1'b0));
		send_item(cc_item(CMD_LOST, 16'd500, base + 63'd20, '0, 62'd12, base + 63'd20,
			63'd100, 1'b1));
		base = t_now[62:0];
		send_item(cc_item(CMD_LOST, 16'd700, base, '0, 62'd20, base + 63'd30, 63'd1000,
			1'b0));
		send_item(cc_item(CMD_LOST, 16'd700, base + 63'd30, '0, 62'd22, base + 63'd30,
			63'd1000, 1'b1));
		base = t_now[62:0];
		send_item(cc_item(CMD_LOST, 16'hFFFF, base, '0, 62'd30, base + 63'd1000, 63'd5,
			1'b0));
		send_item(cc_item(CMD_LOST, 16'hFFFF, base + 63'd1000, '0, 62'd31, base + 63'd1000,
			63'd5, 1'b1));
		pn_ctr = 64'd100;
	endtask

	// a zero window reached through a zero factor grows by whole acked bytes, then in avoidance
	task automatic test_zero_window();
		apply_settings(16'd1200, 32'd0, 32'd0, 16'd0);
		ce_ctr = ce_ctr + 62'd1;
		send_item(cc_item(CMD_ECN, 16'd0, t_now[62:0], ce_ctr, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'd500, t_now[62:0], '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'd900, t_now[62:0], '0, '0, '0, '0, 1'b0));
	endtask

	// window pinned near all ones, then slow start runs into the ceiling
	task automatic test_window_ceiling();
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		ce_ctr = ce_ctr + 62'd1;
		send_item(cc_item(CMD_ECN, 16'd0, t_now[62:0], ce_ctr, '0, '0, '0, 1'b0));
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00, 16'hFFFF);
		send_item(cc_item(CMD_LOST, 16'd0, '0, '0, 62'd40, '0, '0, 1'b1));
		send_item(cc_item(CMD_ACK, 16'hFFFF, t_now[62:0], '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'hFFFF, t_now[62:0], '0, '0, '0, '0, 1'b0));
	endtask

	// mostly well-formed traffic with a share of noise
	task automatic run_traffic(int count);
		int n;
		int pick;
		int batch;
		int gap;
		logic [62:0] first;
		logic [62:0] per;
		logic [15:0] sz;
		cc_item_t it;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			sz = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
			if (pick < 33) begin
				send_item(cc_item(CMD_SENT, sz, '0, '0, '0, '0, '0, 1'b0));
				n++;
			end else if (pick < 63) begin
				first = t_now[62:0] - 63'($urandom_range(0, 4000));
				send_item(cc_item(CMD_ACK, sz, first, '0, '0, '0, '0, 1'b0));
				n++;
			end else if (pick < 72) begin
				if ($urandom_range(3) != 0)
					ce_ctr = ce_ctr + 62'($urandom_range(1, 3));
				first = t_now[62:0] - 63'($urandom_range(0, 4000));
				send_item(cc_item(CMD_ECN, 16'd0, first, ce_ctr, '0, '0, '0, 1'b0));
				n++;
			end else if (pick < 88) begin
				// one loss batch in packet number order, repeats and gaps included
				batch = $urandom_range(1, 6);
				gap = $urandom_range(0, 2000);
				per = 63'($urandom_range(0, 9000));
				first = t_now[62:0] - 63'($urandom_range(0, 12000));
				for (int k = 0; k < batch; k++) begin
					pick = $urandom_range(99);
					if (k > 0 && pick < 15)
						pn_ctr = pn_ctr + 64'($urandom_range(2, 4));
					else if (k == 0 || pick >= 20)
						pn_ctr = pn_ctr + 64'd1;
					send_item(cc_item(CMD_LOST, sz, first + 63'(gap * k), '0, pn_ctr[61:0],
						first + 63'(gap * (batch - 1)), per,
						k == batch - 1 && $urandom_range(9) != 0));
				end
				n += batch;
			end else begin
				// noise: any kind, wide fields, now time and ce kept in the running range
				it = cc_item(cmd_t'($urandom_range(3)), 16'($urandom), rand63(),
					(ce_ctr > 62'd3) ? ce_ctr - 62'($urandom_range(0, 3)) : 62'd0, rand62(),
					rand63(), rand63(), 1'($urandom));
				send_item(it);
				n++;
			end
		end
	endtask

	// several register settings, extremes among them
	task automatic test_random_traffic();
		apply_settings(MDS_RESET, IWND_RESET, MWND_RESET, FACT_RESET);
		run_traffic(215);
		apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
		tx_steady = 1'b1;
		rx_steady <= 1'b1;
		run_traffic(215);
		tx_steady = 1'b0;
		rx_steady <= 1'b0;
		apply_settings(16'd1200, 32'd0, 32'd0, 16'd0);
		run_traffic(215);
		apply_settings(16'($urandom_range(1200, 65535)), $urandom, $urandom_range(0, 100000),
			16'($urandom));
		run_traffic(215);
		apply_settings(16'hFFFF, $urandom, 32'hFFFF_FFFF, 16'd1);
		run_traffic(110);
		apply_settings(16'($urandom_range(1200, 9000)), $urandom, $urandom_range(1200, 20000),
			16'($urandom_range(20000, 60000)));
		run_traffic(110);
	endtask

	// receiver holds off while the sender keeps offering requests
	task automatic test_output_backpressure();
		tx_steady = 1'b1;
		hold_req <= hold_req + 8'd1;
		run_traffic(40);
		tx_steady = 1'b0;
	endtask

	// full-size sends pile up bytes in flight, then a loss and an ack bring them down
	task automatic test_inflight_ceiling();
		tx_steady = 1'b1;
		rx_steady <= 1'b1;
		for (int i = 0; i < 8; i++)
			send_item(cc_item(CMD_SENT, 16'hFFFF, '0, '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_LOST, 16'hFFFF, '0, '0, 62'd7, TIME_MAX, '0, 1'b0));
		send_item(cc_item(CMD_ACK, 16'hFFFF, t_now[62:0], '0, '0, '0, '0, 1'b0));
		tx_steady = 1'b0;
		rx_steady <= 1'b0;
	endtask

	// full-width fields everywhere, ends with every time at its maximum
	task automatic test_field_extremes();
		cc_item_t it;
		for (int i = 0; i < 40; i++) begin
			it = cc_item(cmd_t'($urandom_range(3)), 16'($urandom), rand63(), rand62(),
				rand62(), rand63(), rand63(), 1'($urandom));
			it.now = rand63();
			send_item(it);
		end
		it = cc_item(CMD_LOST, 16'hFFFF, TIME_MAX, '0, CNT_MAX, TIME_MAX, TIME_MAX, 1'b1);
		it.now = TIME_MAX;
		send_item(it);
		send_item(cc_item(CMD_ACK, 16'hFFFF, TIME_MAX, '0, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_ECN, 16'd0, TIME_MAX, CNT_MAX, '0, '0, '0, 1'b0));
		send_item(cc_item(CMD_SENT, 16'hFFFF, '0, '0, '0, '0, '0, 1'b0));
	endtask

	// result side ready, with random stalls and counted hold-offs
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= RX_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 28);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 100)
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// compare each status result against the oldest prediction
	always @(posedge clk) begin : check_status
		cc_status_t got;
		cc_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.credit = m_tdata[0];
			got.room = m_tdata[32:1];
			got.inflight = m_tdata[64:33];
			got.cwnd = m_tdata[96:65];
			got.ssthresh = m_tdata[128:97];
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 100)
					$display("%0t ns: unexpected status, expected none, actual %h", $time,
						m_tdata);
			end else begin
				want = status_due.pop_front();
				check_field("credit_ok", {31'd0, want.credit}, {31'd0, got.credit});
				check_field("window_open", want.room, got.room);
				check_field("inflight_bytes", want.inflight, got.inflight);
				check_field("cwnd_bytes", want.cwnd, got.cwnd);
				check_field("slow_start_threshold", want.ssthresh, got.ssthresh);
			end
		end
	end

	// progress watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_ecn_reaction();
		test_loss_batches();
		test_zero_window();
		test_window_ceiling();
		test_random_traffic();
		test_output_backpressure();
		test_inflight_ceiling();
		test_field_extremes();
		settle();
		repeat (40) @(posedge clk);
		$display("run: %0d event requests, %0d status results, %0d register settings",
			items_sent, results_seen, settings_done);
		$display("run: ecn and loss reactions, recovery, zero and full windows, output stall");
		if (mismatches == 0 && status_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
